[hdl/page_frame_allocator_refcount_top_assert.svh]
// Assertion macros shared by the page frame allocator RTL.
// Each macro expects clk and arst_n in scope.
`ifndef PAGE_FRAME_ALLOCATOR_REFCOUNT_TOP_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_REFCOUNT_TOP_ASSERT_SVH

// Same-cycle implication.
`define PFA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PFA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/pfa_pkg.sv]
`default_nettype none

package pfa_pkg;

	// Fixed field widths
	localparam int unsigned PAGE_W   = 12;
	localparam int unsigned CNT_W    = 16;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned OP_W     = 2;
	localparam int unsigned PCNT_W   = 13;

	// Stream packing
	localparam int unsigned IN_TDATA_W  = ((PAGE_W + 7) / 8) * 8;
	localparam int unsigned OUT_TDATA_W = ((PAGE_W + CNT_W + 7) / 8) * 8;
	localparam int unsigned OUT_TUSER_W = STATUS_W + 1;

	// Largest page number space addressable by the page field
	localparam int unsigned PAGE_SPACE = 1 << PAGE_W;

	localparam int unsigned NUM_PAGES_DEF = 4096;
	localparam logic [PCNT_W-1:0] PAGE_COUNT_RST = PCNT_W'(4096);
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_INCREF = 2'd2,
		OP_DECREF = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_NOMEM     = 3'd1,
		STAT_BADPAGE   = 3'd2,
		STAT_OVERFLOW  = 3'd3,
		STAT_UNDERFLOW = 3'd4,
		STAT_FULL      = 3'd5
	} status_t;

endpackage

`default_nettype wire

[hdl/pfa_ram.sv]
`default_nettype none

module pfa_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single write port, registered read port; rdata holds when not reading
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[hdl/page_frame_allocator_refcount_top.sv]
// Page frame allocator with per-page reference counts.
// Input stream (s_axis_*): one operation per transfer, op in tuser
// (alloc, free, incref, decref) and the page number in tdata.
// Output stream (m_axis_*): exactly one result per input transfer, in order:
// status and freed flag in tuser, page and count after the operation in tdata.
// Config channel (cfg_*): writes page_count; always ready.
// Each item is handled by first reading the count memory and the free-stack
// memory (registered reads), then deciding and writing both back.
// A new item is taken once the current one is written back; the result is
// valid the cycle after the write-back and sits in an output register, so
// the next item can be accepted while it waits.
// If the receiver stalls with a result still held, the following item waits
// in its write-back cycle until the output register frees up.
// After reset the count memory is swept to zero, one entry per cycle;
// s_axis_tready stays low during the sweep.
// The free list starts empty and page_count resets to 4096.
`default_nettype none

module page_frame_allocator_refcount_top #(
	parameter int unsigned NUM_PAGES = pfa_pkg::NUM_PAGES_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// s_axis_tdata: page_index [11:0], zero pad [15:12]
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  wire logic [pfa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// s_axis_tuser: op [1:0]
	input  wire logic [pfa_pkg::OP_W-1:0]           s_axis_tuser,
	// m_axis_tdata: page_out [11:0], ref_after [27:12], zero pad [31:28]
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	output logic      [pfa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// m_axis_tuser: status [2:0], freed [3]
	output logic      [pfa_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [pfa_pkg::PCNT_W-1:0]         cfg_data
);

	import pfa_pkg::*;

`include "page_frame_allocator_refcount_top_assert.svh"

	localparam int unsigned TOP_W     = $clog2(NUM_PAGES + 1);
	localparam int unsigned STK_AW    = $clog2(NUM_PAGES);
	localparam int unsigned REF_DEPTH = (NUM_PAGES < PAGE_SPACE) ? NUM_PAGES : PAGE_SPACE;
	localparam int unsigned REF_AW    = $clog2(REF_DEPTH);
	localparam int unsigned OUT_PAD_W = OUT_TDATA_W - PAGE_W - CNT_W;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t              state_q;
	op_t                 op_q;
	logic [PAGE_W-1:0]   page_q;
	logic [TOP_W-1:0]    free_top_q;
	logic [PCNT_W-1:0]   page_count_q;
	logic                clear_done_q;
	logic [REF_AW-1:0]   clear_addr_q;

	logic                out_valid_q;
	status_t             out_status_q;
	logic [PAGE_W-1:0]   out_page_q;
	logic [CNT_W-1:0]    out_ref_q;
	logic                out_freed_q;

	logic                in_fire;
	logic                commit;
	logic [TOP_W-1:0]    top_dec;

	// Memory ports
	logic                ref_we;
	logic [REF_AW-1:0]   ref_waddr;
	logic [CNT_W-1:0]    ref_wdata;
	logic [CNT_W-1:0]    ref_rdata;
	logic                stk_we;
	logic [PAGE_W-1:0]   stk_rdata;

	// Write-back decision
	status_t             n_status;
	logic [PAGE_W-1:0]   n_page;
	logic [CNT_W-1:0]    n_ref;
	logic                n_freed;
	logic                x_ref_we;
	logic [REF_AW-1:0]   x_ref_waddr;
	logic [CNT_W-1:0]    x_ref_wdata;
	logic                x_push;
	logic                x_pop;
	logic                stack_empty;
	logic                stack_full;
	logic                page_ok;

	// Handshakes
	assign s_axis_tready = (state_q == S_IDLE) && clear_done_q;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign commit        = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready);
	assign cfg_ready     = 1'b1;
	assign top_dec       = free_top_q - 1'b1;

	// Count memory: one entry per manageable page
	pfa_ram #(
		.WIDTH (CNT_W),
		.DEPTH (REF_DEPTH)
	) u_ref_ram (
		.clk   (clk),
		.we    (ref_we),
		.waddr (ref_waddr),
		.wdata (ref_wdata),
		.re    (in_fire),
		.raddr (s_axis_tdata[REF_AW-1:0]),
		.rdata (ref_rdata)
	);

	// Free-stack memory; read the current top on accept
	pfa_ram #(
		.WIDTH (PAGE_W),
		.DEPTH (NUM_PAGES)
	) u_stk_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (free_top_q[STK_AW-1:0]),
		.wdata (page_q),
		.re    (in_fire),
		.raddr (top_dec[STK_AW-1:0]),
		.rdata (stk_rdata)
	);

	// Status flags for the item in write-back
	assign stack_empty = (free_top_q == '0);
	assign stack_full  = (free_top_q >= TOP_W'(NUM_PAGES));
	assign page_ok     = ({1'b0, page_q} < page_count_q) && (32'(page_q) < 32'(NUM_PAGES));

	// Operation decode and new count
	always_comb begin
		n_status    = STAT_OK;
		n_page      = page_q;
		n_ref       = '0;
		n_freed     = 1'b0;
		x_ref_we    = 1'b0;
		x_ref_waddr = page_q[REF_AW-1:0];
		x_ref_wdata = '0;
		x_push      = 1'b0;
		x_pop       = 1'b0;
		if (op_q == OP_ALLOC) begin
			if (stack_empty) begin
				n_status = STAT_NOMEM;
				n_page   = '0;
			end else begin
				x_pop  = 1'b1;
				n_page = stk_rdata;
				if (32'(stk_rdata) < 32'(NUM_PAGES)) begin
					x_ref_we    = 1'b1;
					x_ref_waddr = stk_rdata[REF_AW-1:0];
				end
			end
		end else if (!page_ok) begin
			n_status = STAT_BADPAGE;
		end else begin
			n_ref = ref_rdata;
			case (op_q)
				OP_FREE: begin
					if (stack_full) begin
						n_status = STAT_FULL;
					end else begin
						x_push   = 1'b1;
						x_ref_we = 1'b1;
						n_ref    = '0;
					end
				end
				OP_INCREF: begin
					if (ref_rdata == CNT_MAX) begin
						n_status = STAT_OVERFLOW;
					end else begin
						x_ref_we    = 1'b1;
						x_ref_wdata = ref_rdata + 1'b1;
						n_ref       = ref_rdata + 1'b1;
					end
				end
				OP_DECREF: begin
					if (ref_rdata == '0) begin
						n_status = STAT_UNDERFLOW;
					end else if (ref_rdata == CNT_W'(1)) begin
						if (stack_full) begin
							n_status = STAT_FULL;
						end else begin
							x_push   = 1'b1;
							x_ref_we = 1'b1;
							n_ref    = '0;
							n_freed  = 1'b1;
						end
					end else begin
						x_ref_we    = 1'b1;
						x_ref_wdata = ref_rdata - 1'b1;
						n_ref       = ref_rdata - 1'b1;
					end
				end
				default: begin
					n_status = STAT_OK;
				end
			endcase
		end
	end

	// Count memory write port: reset sweep first, then write-back
	always_comb begin
		if (!clear_done_q) begin
			ref_we    = 1'b1;
			ref_waddr = clear_addr_q;
			ref_wdata = '0;
		end else begin
			ref_we    = x_ref_we && commit;
			ref_waddr = x_ref_waddr;
			ref_wdata = x_ref_wdata;
		end
	end

	assign stk_we = x_push && commit;

	// Control, stack pointer, config and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			free_top_q   <= '0;
			page_count_q <= PAGE_COUNT_RST;
			clear_done_q <= 1'b0;
			clear_addr_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (!clear_done_q) begin
				if (clear_addr_q == REF_AW'(REF_DEPTH - 1)) begin
					clear_done_q <= 1'b1;
				end else begin
					clear_addr_q <= clear_addr_q + 1'b1;
				end
			end
			if (cfg_valid && cfg_ready) begin
				page_count_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (commit) begin
				if (x_push) begin
					free_top_q <= free_top_q + 1'b1;
				end else if (x_pop) begin
					free_top_q <= top_dec;
				end
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q   <= op_t'(s_axis_tuser);
			page_q <= s_axis_tdata[PAGE_W-1:0];
		end
		if (commit) begin
			out_status_q <= n_status;
			out_page_q   <= n_page;
			out_ref_q    <= n_ref;
			out_freed_q  <= n_freed;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_ref_q, out_page_q};
	assign m_axis_tuser  = {out_freed_q, out_status_q};

	// Checks
	`PFA_ASSERT_IMP(a_no_accept_in_sweep, s_axis_tready, clear_done_q, "item taken during sweep")
	`PFA_ASSERT_IMP(a_top_bound, 1'b1, free_top_q <= TOP_W'(NUM_PAGES), "stack pointer past end")
	`PFA_ASSERT_NXT(a_commit_out, commit, out_valid_q && (state_q == S_IDLE), "write-back lost")
	`PFA_ASSERT_IMP(a_freed_ok, out_valid_q && out_freed_q, out_status_q == STAT_OK, "freed on error")

endmodule

`default_nettype wire

[tb/tb_page_frame_allocator_refcount_top.sv]
module tb_page_frame_allocator_refcount_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pfa_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int HOLDOFF_AFTER  = 300;

	typedef struct {
		op_t               op;
		logic [PAGE_W-1:0] page;
	} page_req_t;

	typedef struct {
		status_t           status;
		logic [PAGE_W-1:0] page;
		logic [CNT_W-1:0]  refs;
		logic              freed;
	} page_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [OP_W-1:0]        s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [OUT_TUSER_W-1:0] m_axis_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [PCNT_W-1:0]      cfg_data = '0;

	// Predictor state: free list, per-page counts, page limit
	logic [PAGE_W-1:0] free_list [PAGE_SPACE];
	int                list_depth = 0;
	logic [CNT_W-1:0]  ref_count [PAGE_SPACE];
	logic [PCNT_W-1:0] page_limit = PAGE_COUNT_RST;

	page_req_t    pending_ops[$];
	page_result_t expected_results[$];

	int   error_count = 0;
	int   results_seen = 0;
	int   holdoff_left = 0;
	bit   holdoff_done = 1'b0;
	bit   burst_mode = 1'b0;
	int   stall_cycles = 0;

	page_frame_allocator_refcount_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Push a page onto the free list; false when the list is full
	function automatic bit push_free(logic [PAGE_W-1:0] pg);
		if (list_depth >= PAGE_SPACE)
			return 1'b0;
		free_list[list_depth] = pg;
		list_depth++;
		return 1'b1;
	endfunction

	// Apply one operation to the allocator state and return its result
	function automatic page_result_t apply_page_op(op_t kind, logic [PAGE_W-1:0] pg);
		page_result_t r;
		logic [CNT_W-1:0] cnt;
		r = '{status: STAT_OK, page: pg, refs: '0, freed: 1'b0};
		if (kind == OP_ALLOC) begin
			if (list_depth == 0) begin
				r.status = STAT_NOMEM;
				r.page = '0;
			end else begin
				list_depth--;
				r.page = free_list[list_depth];
				ref_count[r.page] = '0;
			end
		end else if ({1'b0, pg} >= page_limit) begin
			r.status = STAT_BADPAGE;
		end else begin
			cnt = ref_count[pg];
			r.refs = cnt;
			case (kind)
				OP_FREE: begin
					if (push_free(pg)) begin
						ref_count[pg] = '0;
						r.refs = '0;
					end else begin
						r.status = STAT_FULL;
					end
				end
				OP_INCREF: begin
					if (cnt == CNT_MAX) begin
						r.status = STAT_OVERFLOW;
					end else begin
						ref_count[pg] = cnt + 1'b1;
						r.refs = cnt + 1'b1;
					end
				end
				default: begin
					if (cnt == '0) begin
						r.status = STAT_UNDERFLOW;
					end else if (cnt == CNT_W'(1)) begin
						// last reference dropped: page goes back on the list
						if (push_free(pg)) begin
							ref_count[pg] = '0;
							r.refs = '0;
							r.freed = 1'b1;
						end else begin
							r.status = STAT_FULL;
						end
					end else begin
						ref_count[pg] = cnt - 1'b1;
						r.refs = cnt - 1'b1;
					end
				end
			endcase
		end
		return r;
	endfunction

	function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
			error_count++;
		end
	endfunction

	// Request side: predict on each transfer, then offer the next pending op
	always @(posedge clk) begin
		page_req_t nxt;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(apply_page_op(op_t'(s_axis_tuser),
					s_axis_tdata[PAGE_W-1:0]));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_ops.size() != 0 && (burst_mode || $urandom_range(99) >= 33)) begin
					nxt = pending_ops.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= nxt.op;
					s_axis_tdata <= IN_TDATA_W'(nxt.page);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result side: compare each transfer with the oldest prediction
	always @(posedge clk) begin
		page_result_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$error("result transfer with no request outstanding");
					error_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("status", 32'(want.status), 32'(m_axis_tuser[STATUS_W-1:0]));
					check_field("page_out", 32'(want.page), 32'(m_axis_tdata[PAGE_W-1:0]));
					check_field("ref_after", 32'(want.refs),
						32'(m_axis_tdata[PAGE_W +: CNT_W]));
					check_field("freed", 32'(want.freed), 32'(m_axis_tuser[STATUS_W]));
				end
			end
			// one long backpressure window, otherwise random stalls
			if (holdoff_left != 0) begin
				holdoff_left--;
				m_axis_tready <= 1'b0;
			end else if (!holdoff_done && results_seen >= HOLDOFF_AFTER) begin
				holdoff_done = 1'b1;
				holdoff_left = HOLDOFF_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= burst_mode || ($urandom_range(99) >= 33);
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic void queue_op(op_t kind, logic [PAGE_W-1:0] pg);
		pending_ops.push_back('{op: kind, page: pg});
	endfunction

	// Mostly a small hot set of pages so counts climb, drain and free;
	// some uniform pages and some from the full page field
	task automatic queue_random_ops(int n);
		logic [PAGE_W-1:0] hot [8];
		logic [PAGE_W-1:0] pg;
		op_t kind;
		int r;
		foreach (hot[i])
			hot[i] = PAGE_W'($urandom_range(int'(page_limit) - 1));
		repeat (n) begin
			r = $urandom_range(99);
			kind = (r < 30) ? OP_ALLOC : (r < 50) ? OP_FREE : (r < 75) ? OP_INCREF : OP_DECREF;
			r = $urandom_range(99);
			if (r < 70)
				pg = hot[$urandom_range(7)];
			else if (r < 90)
				pg = PAGE_W'($urandom_range(int'(page_limit) - 1));
			else
				pg = PAGE_W'($urandom_range(PAGE_SPACE - 1));
			queue_op(kind, pg);
		end
	endtask

	// Called right after a rising edge with the block idle
	task automatic write_page_count(logic [PCNT_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		page_limit = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_ops.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		logic [PCNT_W-1:0] limits [4];
		foreach (ref_count[i])
			ref_count[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_page_count(PAGE_COUNT_RST);

		// Empty list, underflow, count up and back down to a free, double free
		queue_op(OP_ALLOC, 12'hABC);
		queue_op(OP_DECREF, 12'd0);
		queue_op(OP_INCREF, 12'hFFF);
		queue_op(OP_INCREF, 12'hFFF);
		queue_op(OP_DECREF, 12'hFFF);
		queue_op(OP_DECREF, 12'hFFF);
		queue_op(OP_DECREF, 12'hFFF);
		queue_op(OP_FREE, 12'd0);
		queue_op(OP_FREE, 12'd0);
		queue_op(OP_ALLOC, 12'd0);
		queue_op(OP_ALLOC, 12'hFFF);
		queue_op(OP_ALLOC, 12'd5);
		queue_op(OP_ALLOC, 12'd0);
		queue_op(OP_FREE, 12'd100);
		queue_op(OP_FREE, 12'd3000);
		wait_idle();

		// Smallest page limit: bad pages, and pages above it still allocatable
		write_page_count(PCNT_W'(1));
		queue_op(OP_ALLOC, 12'd0);
		queue_op(OP_FREE, 12'd1);
		queue_op(OP_INCREF, 12'hFFF);
		queue_op(OP_DECREF, 12'd2);
		queue_op(OP_INCREF, 12'd0);
		queue_op(OP_FREE, 12'd0);
		queue_op(OP_ALLOC, 12'd0);
		queue_op(OP_ALLOC, 12'd0);
		queue_op(OP_ALLOC, 12'd0);
		wait_idle();

		// Random traffic under several page limits
		limits[0] = PAGE_COUNT_RST;
		limits[1] = PCNT_W'($urandom_range(4095, 2));
		limits[2] = PCNT_W'(1);
		limits[3] = PCNT_W'(64);
		foreach (limits[i]) begin
			write_page_count(limits[i]);
			queue_random_ops(400);
			wait_idle();
		end

		// Mid-range limit with both sides running flat out
		write_page_count(PCNT_W'(2048));
		burst_mode = 1'b1;
		queue_random_ops(250);
		wait_idle();
		burst_mode = 1'b0;

		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[sim.f]
+incdir+hdl
hdl/pfa_pkg.sv
hdl/pfa_ram.sv
hdl/page_frame_allocator_refcount_top.sv
tb/tb_page_frame_allocator_refcount_top.sv
